>>> hw/rtl/mie_pkg.sv
// Package for the modular inverse block: shared types and constants.
// No dependencies.
package mie_pkg;

  localparam int unsigned WordBits = 64;

  typedef struct packed {
    logic load;     // load operands, start a round
    logic div_go;   // start one division
    logic step;     // apply quotient/remainder update
  } mie_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic done_cond; // r_cur == 0 or r_prev == 0
  } mie_sts_t;

endpackage

>>> hw/rtl/mie_if.sv
// Valid/ready channel interface carrying one payload beat.
// No dependencies.
interface mie_if #(
  parameter int unsigned W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/modular_inverse_ext_euclid.sv
// Modular inverse by extended Euclid: one item at a time.
// The bit-serial divider yields one quotient bit per cycle; the next item is
// accepted in the cycle after the result is taken.
// Reset rst_ni async low returns the controller to idle; no memory clearing.
module modular_inverse_ext_euclid #(
  parameter int unsigned VALUE_BITS = 63
) (
  input logic clk_i,
  input logic rst_ni,
  mie_if.sink   in_if,   // data = {value, modulus}
  mie_if.source out_if   // data = inverse
);
  import mie_pkg::*;
  mie_cmd_t cmd;
  mie_sts_t sts;

  mie_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid), .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  // result registers hold until the next load, so out data is stable
  mie_datapath #(.VALUE_BITS(VALUE_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .mod_i(in_if.data[VALUE_BITS-1:0]),
    .val_i(in_if.data[2*VALUE_BITS-1:VALUE_BITS]),
    .sts_o(sts), .inv_o(out_if.data)
  );
endmodule

>>> hw/rtl/mie_datapath.sv
// Datapath: remainder/coefficient registers, a bit-serial divider and a
// shift-add quotient-times-coefficient product built alongside it.
// Depends on mie_pkg.
module mie_datapath #(
  parameter int unsigned VALUE_BITS = 63
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mie_pkg::mie_cmd_t      cmd_i,
  input  logic [VALUE_BITS-1:0]  mod_i,
  input  logic [VALUE_BITS-1:0]  val_i,
  output mie_pkg::mie_sts_t      sts_o,
  output logic [VALUE_BITS-1:0]  inv_o
);
  import mie_pkg::*;
  localparam int unsigned CntW = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] a_q, r_cur_q, r_prev_q, quo_q, rem_q;
  logic [WordBits-1:0]   c_cur_q, c_prev_q;
  logic [CntW-1:0]       cnt_q;
  logic                  busy_q;
  logic [VALUE_BITS:0]   trial;
  logic [WordBits-1:0]   prod_q, coef;

  // restoring division: one quotient bit per cycle, dividend bits from quo_q
  assign trial = {rem_q, quo_q[VALUE_BITS-1]} - {1'b0, r_cur_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.div_go) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(VALUE_BITS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_go) begin
      quo_q  <= r_prev_q;
      rem_q  <= '0;
      prod_q <= '0;
    end else if (busy_q) begin
      // quotient bits come MSB first: q*c_cur builds up by Horner's rule, mod 2^64
      prod_q <= {prod_q[WordBits-2:0], 1'b0} + (trial[VALUE_BITS] ? '0 : c_cur_q);
      if (!trial[VALUE_BITS]) begin
        rem_q <= trial[VALUE_BITS-1:0];
        quo_q <= {quo_q[VALUE_BITS-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[VALUE_BITS-2:0], quo_q[VALUE_BITS-1]};
        quo_q <= {quo_q[VALUE_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q      <= mod_i;
      r_prev_q <= mod_i;
      r_cur_q  <= val_i;
      c_prev_q <= '0;
      c_cur_q  <= WordBits'(1);
    end else if (cmd_i.step) begin
      r_prev_q <= r_cur_q;
      r_cur_q  <= rem_q;
      c_prev_q <= c_cur_q;
      c_cur_q  <= c_prev_q - prod_q;
    end
  end

  assign sts_o.div_busy  = busy_q;
  assign sts_o.done_cond = (r_cur_q == '0) || (r_prev_q == '0);

  always_comb begin
    coef = (r_cur_q == '0) ? c_prev_q : c_cur_q;
    if (coef[WordBits-1]) coef = coef + WordBits'(a_q);
    inv_o = coef[VALUE_BITS-1:0];
  end
endmodule

>>> hw/rtl/mie_ctrl.sv
// Controller FSM sequencing Euclid rounds and the output beat.
// Depends on mie_pkg.
module mie_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  mie_pkg::mie_sts_t sts_i,
  output mie_pkg::mie_cmd_t cmd_o
);
  import mie_pkg::*;
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_CHECK = 5'b00010, S_DIV = 5'b00100,
    S_STEP = 5'b01000, S_OUT = 5'b10000
  } state_e;
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.done_cond) state_d = S_OUT;
        else begin
          cmd_o.div_go = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: if (!sts_i.div_busy) state_d = S_STEP;
      S_STEP: begin
        cmd_o.step = 1'b1;
        state_d = S_CHECK;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

>>> hw/rtl/mie_checker.sv
// Port-level checker for the modular inverse block, bound to the top.
// Depends on modular_inverse_ext_euclid, the bind target.
module mie_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);
  // never accepts while a result is pending
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i)) else $error("ready while result pending");
  // an accepted beat is never answered in the next cycle
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !out_valid_i) else $error("result too early");
  // after a delivered result the block is ready again
  a_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i) |=> in_ready_i) else $error("not ready after result");
  // result stays until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i) else $error("result dropped");
endmodule

bind modular_inverse_ext_euclid mie_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready)
);
